FILE: rtl/core/dic_pkg.sv
// Shared types and constants for the decimal/integer literal canonicaliser.
`default_nettype none
package dic_pkg;

  localparam int unsigned ZeroRunMax = 62;
  localparam int unsigned RunW       = 6;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = 2;
  localparam int unsigned QCntW      = 3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [RunW-1:0] ZERO_RUN_MAX = RunW'(ZeroRunMax);

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
    logic       integer_form;
  } lit_word_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       done_res;
    logic       bad_text;
  } canon_word_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC,
    PH_TRAIL
  } phase_t;

  typedef enum logic [2:0] {
    CMD_CHAR,      // one byte
    CMD_ZPT,       // "0."
    CMD_RUN,       // run zeros, then the byte
    CMD_END_NONE,  // final word, no byte
    CMD_END_BAD,   // final word, rejected
    CMD_END_Z,     // "0"
    CMD_END_ZPZ,   // "0.0"
    CMD_END_PZ     // ".0"
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic [7:0]      ch;
    logic [RunW-1:0] run;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/dic_front.sv
// Front end: parses the literal grammar and turns each word into an emit command.
`default_nettype none
module dic_front (
  input  wire                clk,
  input  wire                rst,
  input  wire                lit_valid,
  output logic               lit_stall,
  input  dic_pkg::lit_word_t lit,
  input  wire                q_full,
  output logic               push,
  output dic_pkg::cmd_t      push_cmd
);
  import dic_pkg::*;

  phase_t          phase, phase_next;
  logic            int_digit_seen, int_digit_seen_next;
  logic            point_seen, point_seen_next;
  logic            frac_digit_emitted, frac_digit_emitted_next;
  logic [RunW-1:0] zero_run, zero_run_next;
  logic            failed, failed_next;

  logic       accept;
  logic [7:0] c;
  logic       is_ws, is_dig, is_sign, eff_int, signif;

  assign lit_stall = q_full;
  assign accept    = lit_valid && !lit_stall;
  assign c         = lit.char_in;

  always_comb begin
    is_ws  = c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    is_dig = c inside {[CH_ZERO:CH_NINE]};
  end

  assign is_sign = (c == CH_PLUS) || (c == CH_MINUS);
  // leading phase falls straight into the integer rules on anything else
  assign eff_int = (phase == PH_INT) || (phase == PH_LEAD && !is_ws && !is_sign);
  assign signif  = (c != CH_ZERO) || int_digit_seen;

  // next state
  always_comb begin
    phase_next              = phase;
    int_digit_seen_next     = int_digit_seen;
    point_seen_next         = point_seen;
    frac_digit_emitted_next = frac_digit_emitted;
    zero_run_next           = zero_run;
    failed_next             = failed;
    if (accept) begin
      if (lit.end_of_text) begin
        phase_next              = PH_LEAD;
        int_digit_seen_next     = 1'b0;
        point_seen_next         = 1'b0;
        frac_digit_emitted_next = 1'b0;
        zero_run_next           = '0;
        failed_next             = 1'b0;
      end else if (!failed) begin
        if (phase == PH_LEAD && is_sign) begin
          phase_next = PH_INT;
        end else if (eff_int) begin
          phase_next = PH_INT;
          if (is_dig) begin
            if (signif) int_digit_seen_next = 1'b1;
          end else if (c == CH_POINT && !lit.integer_form) begin
            point_seen_next = 1'b1;
            phase_next      = PH_FRAC;
          end else if (is_ws) begin
            phase_next = PH_TRAIL;
          end else begin
            failed_next = 1'b1;
          end
        end else if (phase == PH_FRAC) begin
          if (c == CH_ZERO) begin
            if (zero_run >= ZERO_RUN_MAX) failed_next = 1'b1;
            else zero_run_next = zero_run + 1'b1;
          end else if (is_dig) begin
            zero_run_next           = '0;
            frac_digit_emitted_next = 1'b1;
          end else if (is_ws) begin
            phase_next = PH_TRAIL;
          end else begin
            failed_next = 1'b1;
          end
        end else if (phase == PH_TRAIL) begin
          if (!is_ws) failed_next = 1'b1;
        end
      end
    end
  end

  // command output
  always_comb begin
    push          = 1'b0;
    push_cmd.kind = CMD_CHAR;
    push_cmd.ch   = c;
    push_cmd.run  = zero_run;
    if (accept) begin
      if (lit.end_of_text) begin
        push = 1'b1;
        if (failed)                  push_cmd.kind = CMD_END_BAD;
        else if (point_seen)         push_cmd.kind = frac_digit_emitted ? CMD_END_NONE
                                                                        : CMD_END_Z;
        else if (lit.integer_form)   push_cmd.kind = int_digit_seen ? CMD_END_NONE
                                                                    : CMD_END_Z;
        else                         push_cmd.kind = int_digit_seen ? CMD_END_PZ
                                                                    : CMD_END_ZPZ;
      end else if (!failed) begin
        if (phase == PH_LEAD && is_sign) begin
          push = (c == CH_MINUS);
        end else if (eff_int) begin
          if (is_dig) begin
            push = signif;
          end else if (c == CH_POINT && !lit.integer_form) begin
            push          = 1'b1;
            push_cmd.kind = int_digit_seen ? CMD_CHAR : CMD_ZPT;
          end
        end else if (phase == PH_FRAC && is_dig && c != CH_ZERO) begin
          push          = 1'b1;
          push_cmd.kind = CMD_RUN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_LEAD;
      int_digit_seen     <= 1'b0;
      point_seen         <= 1'b0;
      frac_digit_emitted <= 1'b0;
      zero_run           <= '0;
      failed             <= 1'b0;
    end else begin
      phase              <= phase_next;
      int_digit_seen     <= int_digit_seen_next;
      point_seen         <= point_seen_next;
      frac_digit_emitted <= frac_digit_emitted_next;
      zero_run           <= zero_run_next;
      failed             <= failed_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dic_queue.sv
// Short command queue between the parser and the emitter.
`default_nettype none
module dic_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  dic_pkg::cmd_t  push_cmd,
  output logic           full,
  output logic           cmd_valid,
  output dic_pkg::cmd_t  cmd,
  input  wire            pop
);
  import dic_pkg::*;

  cmd_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;

  assign full      = (count == QCntW'(QDepth));
  assign cmd_valid = (count != '0);
  assign cmd       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dic_back.sv
// Back end: expands queued commands into output words, one byte per cycle unless the output stalls.
`default_nettype none
module dic_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cmd_valid,
  input  dic_pkg::cmd_t        cmd,
  output logic                 pop,
  output logic                 canon_valid,
  input  wire                  canon_stall,
  output dic_pkg::canon_word_t canon
);
  import dic_pkg::*;

  logic [1:0]      pos;
  logic [RunW-1:0] zcnt;
  logic            load, last;
  canon_word_t     w;

  assign load = cmd_valid && (!canon_valid || !canon_stall);
  assign pop  = load && last;

  always_comb begin
    w.char_out = CH_NUL;
    w.has_char = 1'b1;
    w.done_res = 1'b0;
    w.bad_text = 1'b0;
    last       = 1'b1;
    case (cmd.kind)
      CMD_CHAR: w.char_out = cmd.ch;
      CMD_ZPT: begin
        w.char_out = (pos == 2'd0) ? CH_ZERO : CH_POINT;
        last       = (pos == 2'd1);
      end
      CMD_RUN: begin
        // deferred zeros first, then the digit that released them
        if (zcnt != cmd.run) begin
          w.char_out = CH_ZERO;
          last       = 1'b0;
        end else begin
          w.char_out = cmd.ch;
        end
      end
      CMD_END_NONE: begin
        w.has_char = 1'b0;
        w.done_res = 1'b1;
      end
      CMD_END_BAD: begin
        w.has_char = 1'b0;
        w.done_res = 1'b1;
        w.bad_text = 1'b1;
      end
      CMD_END_Z: begin
        w.char_out = CH_ZERO;
        w.done_res = 1'b1;
      end
      CMD_END_ZPZ: begin
        w.char_out = (pos == 2'd1) ? CH_POINT : CH_ZERO;
        last       = (pos == 2'd2);
        w.done_res = last;
      end
      CMD_END_PZ: begin
        w.char_out = (pos == 2'd0) ? CH_POINT : CH_ZERO;
        last       = (pos == 2'd1);
        w.done_res = last;
      end
      default: w.has_char = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) canon <= w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      canon_valid <= 1'b0;
      pos         <= '0;
      zcnt        <= '0;
    end else begin
      if (load)              canon_valid <= 1'b1;
      else if (!canon_stall) canon_valid <= 1'b0;
      if (load) begin
        if (last) begin
          pos  <= '0;
          zcnt <= '0;
        end else begin
          pos  <= pos + 1'b1;
          zcnt <= zcnt + 1'b1;
        end
      end
    end
  end

  a_pop_on_load : assert property (@(posedge clk) disable iff (rst) pop |-> load)
    else $error("command popped without a word loaded");
  a_run_bound : assert property (@(posedge clk) disable iff (rst)
      (cmd_valid && cmd.kind == CMD_RUN) |-> (zcnt <= cmd.run))
    else $error("zero run count past its length");
  a_bad_final : assert property (@(posedge clk) disable iff (rst)
      (canon_valid && canon.bad_text) |-> (canon.done_res && !canon.has_char))
    else $error("rejected word is not a bare final word");
  a_mid_idle : assert property (@(posedge clk) disable iff (rst)
      (!cmd_valid) |-> (pos == 2'd0 && zcnt == '0))
    else $error("expansion state left over with queue empty");

endmodule
`default_nettype wire

FILE: rtl/core/decimal_integer_canonicaliser.sv
// Top level: numeric literal canonicaliser, parser and emitter joined by a command queue.
// A word that produces output passes through the command queue, then the output register.
// Throughput: one input word per cycle; the emitter gives one output word per cycle while
//   not stalled; a fraction digit after n held zeros gives n+1 words, a terminator up to 3.
// The four-entry command queue absorbs those bursts; input stalls only when it is full.
// Reset (rst, synchronous): parser state to leading whitespace, queue empty, no output valid.
`default_nettype none
module decimal_integer_canonicaliser (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  lit_valid,
  output logic                 lit_stall,
  input  dic_pkg::lit_word_t   lit,
  output logic                 canon_valid,
  input  wire                  canon_stall,
  output dic_pkg::canon_word_t canon
);
  import dic_pkg::*;

  logic q_full, push, cmd_valid, pop;
  cmd_t push_cmd, cmd;

  dic_front u_front (
    .clk       (clk),
    .rst       (rst),
    .lit_valid (lit_valid),
    .lit_stall (lit_stall),
    .lit       (lit),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  dic_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop)
  );

  dic_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .pop         (pop),
    .canon_valid (canon_valid),
    .canon_stall (canon_stall),
    .canon       (canon)
  );

endmodule
`default_nettype wire

FILE: bench/decimal_integer_canonicaliser_tb.sv
// Testbench for the literal canonicaliser: random and directed literals, self-checking.
module decimal_integer_canonicaliser_tb;
  import dic_pkg::*;

  localparam int LIMIT       = 300000;
  localparam int RAND_ITEMS  = 230;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic      wait_idle;  // sender holds this word until nothing is outstanding
    lit_word_t w;
  } lit_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        lit_valid = 1'b0;
  logic        lit_stall;
  lit_word_t   lit = '0;
  logic        canon_valid;
  logic        canon_stall = 1'b0;
  canon_word_t canon;

  decimal_integer_canonicaliser u_top (
    .clk         (clk),
    .rst         (rst),
    .lit_valid   (lit_valid),
    .lit_stall   (lit_stall),
    .lit         (lit),
    .canon_valid (canon_valid),
    .canon_stall (canon_stall),
    .canon       (canon)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  lit_item_t   lit_q[$];
  lit_item_t   lit_next;
  canon_word_t canon_exp_q[$];
  logic [7:0]  lit_text[$];
  int          n_queued = 0;
  int          n_lit_taken = 0;
  int          n_mismatch = 0;
  int          cycles = 0;
  logic        lit_took = 1'b0;

  // canonicaliser state as predicted
  phase_t          ph = PH_LEAD;
  logic            seen_int = 1'b0;
  logic            seen_point = 1'b0;
  logic            frac_out = 1'b0;
  logic [RunW-1:0] zeros_held = '0;
  logic            rejected = 1'b0;

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic bit is_num_char(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic expect_word(logic [7:0] c, logic has, logic done, logic bad);
    canon_word_t e;
    e.char_out = has ? c : 8'h00;
    e.has_char = has;
    e.done_res = done;
    e.bad_text = bad;
    canon_exp_q.push_back(e);
  endtask

  task automatic canonise(lit_word_t w);
    logic [7:0] c;
    bit         taken;
    c = w.char_in;
    taken = 1'b0;
    if (w.end_of_text) begin
      if (rejected) begin
        expect_word(CH_NUL, 1'b0, 1'b1, 1'b1);
      end else if (seen_point) begin
        if (!frac_out) expect_word(CH_ZERO, 1'b1, 1'b1, 1'b0);
        else expect_word(CH_NUL, 1'b0, 1'b1, 1'b0);
      end else if (w.integer_form) begin
        if (!seen_int) expect_word(CH_ZERO, 1'b1, 1'b1, 1'b0);
        else expect_word(CH_NUL, 1'b0, 1'b1, 1'b0);
      end else begin
        if (!seen_int) expect_word(CH_ZERO, 1'b1, 1'b0, 1'b0);
        expect_word(CH_POINT, 1'b1, 1'b0, 1'b0);
        expect_word(CH_ZERO, 1'b1, 1'b1, 1'b0);
      end
      ph = PH_LEAD;
      seen_int = 1'b0;
      seen_point = 1'b0;
      frac_out = 1'b0;
      zeros_held = '0;
      rejected = 1'b0;
    end else if (!rejected) begin
      if (ph == PH_LEAD) begin
        if (is_ws(c)) begin
          taken = 1'b1;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          ph = PH_INT;
          if (c == CH_MINUS) expect_word(CH_MINUS, 1'b1, 1'b0, 1'b0);
          taken = 1'b1;
        end else begin
          ph = PH_INT;
        end
      end
      if (!taken) begin
        case (ph)
          PH_INT: begin
            if (is_num_char(c)) begin
              if (c != CH_ZERO || seen_int) begin
                seen_int = 1'b1;
                expect_word(c, 1'b1, 1'b0, 1'b0);
              end
            end else if (c == CH_POINT && !w.integer_form) begin
              if (!seen_int) expect_word(CH_ZERO, 1'b1, 1'b0, 1'b0);
              expect_word(CH_POINT, 1'b1, 1'b0, 1'b0);
              seen_point = 1'b1;
              ph = PH_FRAC;
            end else if (is_ws(c)) begin
              ph = PH_TRAIL;
            end else begin
              rejected = 1'b1;
            end
          end
          PH_FRAC: begin
            if (c == CH_ZERO) begin
              if (zeros_held >= ZERO_RUN_MAX) rejected = 1'b1;
              else zeros_held = zeros_held + 1'b1;
            end else if (is_num_char(c)) begin
              repeat (zeros_held) expect_word(CH_ZERO, 1'b1, 1'b0, 1'b0);
              zeros_held = '0;
              frac_out = 1'b1;
              expect_word(c, 1'b1, 1'b0, 1'b0);
            end else if (is_ws(c)) begin
              ph = PH_TRAIL;
            end else begin
              rejected = 1'b1;
            end
          end
          default: begin
            if (!(ph == PH_TRAIL && is_ws(c))) rejected = 1'b1;
          end
        endcase
      end
    end
  endtask

  task automatic push_word(bit idle, logic [7:0] c, bit eot, bit intf);
    lit_item_t it;
    it.wait_idle = idle;
    it.w.char_in = c;
    it.w.end_of_text = eot;
    it.w.integer_form = intf;
    lit_q.push_back(it);
    n_queued++;
  endtask

  task automatic push_text(string s, bit intf);
    for (int i = 0; i < s.len(); i++) push_word(1'b0, s[i], 1'b0, intf);
    push_word(1'b0, CH_NUL, 1'b1, intf);
  endtask

  function automatic logic [7:0] rand_ws();
    case ($urandom_range(0, 5))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0A;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit();
    if ($urandom_range(0, 2) == 0) return CH_ZERO;
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // One literal: mostly well-formed text, some near the zero-run limit, some noise or a stray byte.
  task automatic gen_literal(bit force_idle);
    bit         intf;
    bit         idle;
    int         kind;
    int         pos;
    logic [7:0] junk;
    intf = 1'($urandom_range(0, 1));
    idle = force_idle || ($urandom_range(0, 9) == 0);
    kind = $urandom_range(0, 99);
    pos = -1;
    junk = 8'($urandom_range(0, 255));
    lit_text.delete();
    if (kind < 4) begin
      intf = 1'b0;
      lit_text.push_back(CH_ZERO);
      lit_text.push_back(CH_POINT);
      repeat ($urandom_range(ZeroRunMax - 2, ZeroRunMax + 2)) lit_text.push_back(CH_ZERO);
      if ($urandom_range(0, 1)) lit_text.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
    end else if (kind < 14) begin
      repeat ($urandom_range(1, 4)) lit_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) lit_text.push_back(rand_ws());
      case ($urandom_range(0, 2))
        1: lit_text.push_back(CH_PLUS);
        2: lit_text.push_back(CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(0, 4)) lit_text.push_back(rand_digit());
      if (!intf && $urandom_range(0, 1)) begin
        lit_text.push_back(CH_POINT);
        repeat ($urandom_range(0, 6)) lit_text.push_back(rand_digit());
      end
      repeat ($urandom_range(0, 2)) lit_text.push_back(rand_ws());
      if (kind >= 84) pos = $urandom_range(0, lit_text.size());
    end
    for (int k = 0; k <= lit_text.size(); k++) begin
      if (k == pos) begin
        push_word(idle, junk, 1'b0, intf);
        idle = 1'b0;
      end
      if (k < lit_text.size()) begin
        push_word(idle, lit_text[k], 1'b0, intf ^ ($urandom_range(0, 19) == 0));
        idle = 1'b0;
      end
    end
    push_word(idle, 8'($urandom_range(0, 255)), 1'b1, intf ^ ($urandom_range(0, 19) == 0));
  endtask

  task automatic check_field(string name, logic [7:0] e, logic [7:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, e, a);
      n_mismatch++;
    end
  endtask

  // sender: bursts and gaps, holds a stalled word
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      lit_valid <= 1'b0;
    end else if (lit_valid && !lit_took) begin
      // stalled: word stays put
    end else if (gap_left != 0) begin
      lit_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (lit_q.size() == 0 || (lit_q[0].wait_idle && canon_exp_q.size() != 0)) begin
      lit_valid <= 1'b0;
    end else begin
      lit_next = lit_q.pop_front();
      lit_valid <= 1'b1;
      lit <= lit_next.w;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= $urandom_range(0, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // receiver: stall pattern in random stretches, plus one long hold-off
  int hold_left = 0;
  bit hold_used = 1'b0;
  int stall_left = 0;
  int stall_mode = 0;

  always @(negedge clk) begin
    if (rst) begin
      canon_stall <= 1'b0;
    end else if (hold_left != 0) begin
      canon_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_used && n_lit_taken >= 80) begin
      canon_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(4, 40);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: canon_stall <= 1'b0;
        1: canon_stall <= ($urandom_range(0, 3) == 0);
        default: canon_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // check outgoing words before predicting from the incoming one
  always @(posedge clk) begin
    lit_took <= !rst && lit_valid && !lit_stall;
    if (!rst) begin
      if (canon_valid && !canon_stall) begin
        if (canon_exp_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h", $time, canon);
          n_mismatch++;
        end else begin
          check_field("char_out", canon_exp_q[0].char_out, canon.char_out);
          check_field("has_char", 8'(canon_exp_q[0].has_char), 8'(canon.has_char));
          check_field("done_res", 8'(canon_exp_q[0].done_res), 8'(canon.done_res));
          check_field("bad_text", 8'(canon_exp_q[0].bad_text), 8'(canon.bad_text));
          void'(canon_exp_q.pop_front());
        end
      end
      if (lit_valid && !lit_stall) begin
        canonise(lit);
        n_lit_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int directed;
    push_text("", 1'b0);
    push_text("", 1'b1);
    push_text(".", 1'b0);
    push_text("- ", 1'b0);
    push_text("+0.50 ", 1'b0);
    push_text("-12", 1'b1);
    push_text("1.", 1'b1);
    push_word(1'b0, CH_NUL, 1'b0, 1'b0);
    push_word(1'b0, 8'hFF, 1'b1, 1'b0);
    push_word(1'b0, 8'hFF, 1'b0, 1'b1);
    push_word(1'b0, 8'hFF, 1'b1, 1'b1);
    // integer-form digit closed by a decimal-form terminator
    push_word(1'b0, CH_ZERO + 8'd7, 1'b0, 1'b1);
    push_word(1'b0, CH_NUL, 1'b1, 1'b0);
    directed = n_queued;
    gen_literal(1'b1);
    while (n_queued < directed + RAND_ITEMS) gen_literal(1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (lit_q.size() != 0 || lit_valid) @(negedge clk);
    while (canon_exp_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (canon_exp_q.size() != 0) n_mismatch++;
    if (n_mismatch == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
